// ----- design/aasp_pkg.sv -----
// Shared types and constants for the ASCII attitude sentence parser.
// Used by aasp_field_acc and ascii_attitude_sentence_parser_core; no dependencies.
`default_nettype none

package aasp_pkg;

	localparam int BYTE_W  = 8;
	localparam int PART_W  = 10;  // one decimal part, saturating at 999
	localparam int MAG_W   = 20;  // whole * 1000 + frac, up to 999999
	localparam int ANGLE_W = 21;  // signed angle in thousandths

	localparam logic [PART_W-1:0] PART_MAX = 10'd999;
	localparam logic [MAG_W-1:0]  SCALE    = 20'd1000;

	localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;  // '*'
	localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;  // ','
	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;  // '.'
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'

	// Control from the sentence tracker to the field accumulator
	typedef struct packed {
		logic clear;  // start a fresh field
		logic take;   // feed this character into the current field
	} aasp_field_ctl_t;

	typedef logic signed [ANGLE_W-1:0] aasp_angle_t;

endpackage

`default_nettype wire

// ----- design/aasp_field_acc.sv -----
// Decimal field accumulator: sign, saturating whole and fraction parts, signed value.
// Depends on aasp_pkg.
`default_nettype none

module aasp_field_acc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aasp_pkg::aasp_field_ctl_t     ctl,
	input  wire logic [aasp_pkg::BYTE_W-1:0]   char_in,
	output aasp_pkg::aasp_angle_t              value
);

	logic                          sign_seen_q;
	logic                          negative_q;
	logic                          after_dot_q;
	logic [aasp_pkg::PART_W-1:0]   whole_q;
	logic [aasp_pkg::PART_W-1:0]   frac_q;

	logic                          is_digit;
	logic [3:0]                    digit;
	logic [aasp_pkg::PART_W-1:0]   part_sel;
	logic [13:0]                   part_ext;
	logic [aasp_pkg::PART_W-1:0]   part_next;
	logic [aasp_pkg::MAG_W-1:0]    mag;

	// Next value of the part that the digit goes to, saturated at 999
	always_comb begin
		is_digit  = char_in inside {[aasp_pkg::CHAR_ZERO:aasp_pkg::CHAR_NINE]};
		digit     = 4'(char_in - aasp_pkg::CHAR_ZERO);
		part_sel  = after_dot_q ? frac_q : whole_q;
		part_ext  = 14'(part_sel) * 14'd10 + 14'(digit);
		part_next = (part_ext > 14'(aasp_pkg::PART_MAX)) ? aasp_pkg::PART_MAX
			: aasp_pkg::PART_W'(part_ext);
	end

	// Hold field state; clear on a new field, advance on each field character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_seen_q <= 1'b0;
			negative_q  <= 1'b0;
			after_dot_q <= 1'b0;
			whole_q     <= '0;
			frac_q      <= '0;
		end else if (ctl.clear) begin
			sign_seen_q <= 1'b0;
			negative_q  <= 1'b0;
			after_dot_q <= 1'b0;
			whole_q     <= '0;
			frac_q      <= '0;
		end else if (ctl.take) begin
			if (!sign_seen_q) begin
				negative_q  <= (char_in == aasp_pkg::CHAR_MINUS);
				sign_seen_q <= 1'b1;
			end else if (char_in == aasp_pkg::CHAR_DOT) begin
				after_dot_q <= 1'b1;
			end else if (is_digit) begin
				if (after_dot_q) begin
					frac_q <= part_next;
				end else begin
					whole_q <= part_next;
				end
			end
		end
	end

	// Form the signed value in thousandths
	always_comb begin
		mag   = aasp_pkg::MAG_W'(whole_q) * aasp_pkg::SCALE + aasp_pkg::MAG_W'(frac_q);
		value = negative_q ? -aasp_pkg::aasp_angle_t'({1'b0, mag})
			: aasp_pkg::aasp_angle_t'({1'b0, mag});
	end

endmodule

`default_nettype wire

// ----- design/ascii_attitude_sentence_parser_core.sv -----
// Top level of the ASCII attitude sentence parser: byte register, sentence tracker,
// result register. Depends on aasp_pkg and aasp_field_acc.
`default_nettype none

// Parses NMEA-style attitude sentences one received byte per word. The first header
// character opens a sentence (always, even mid-sentence), '*' closes it and yields one
// result: sentence_ok plus the stored yaw/pitch/roll in thousandths, which change only
// when the sentence began with the full header. The rx channel takes one byte every
// cycle unless stalled; a byte is registered, then processed by the sentence tracker
// and field accumulator, and on '*' the result register loads its result and raises
// res_valid. Only a '*' waiting on a full output register stalls input. The header is
// written through cfg_we/cfg_wdata; the user must write it only while idle, which the
// block itself does not enforce.
module ascii_attitude_sentence_parser_core #(
	parameter int          HEADER_CHARS = 6,
	parameter int          ANGLE_FIELDS = 3,
	parameter logic [63:0] HEADER_RESET = 64'h0000_2456_4E59_4D52
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [8*HEADER_CHARS-1:0]     cfg_wdata,
	input  wire logic                          rx_valid,
	output logic                               rx_ready,
	input  wire logic [aasp_pkg::BYTE_W-1:0]   rx_byte,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic                               sentence_ok,
	output aasp_pkg::aasp_angle_t              yaw_milli,
	output aasp_pkg::aasp_angle_t              pitch_milli,
	output aasp_pkg::aasp_angle_t              roll_milli
);

	localparam int HW  = 8 * HEADER_CHARS;
	localparam int PW  = $clog2(HEADER_CHARS + 1);
	localparam int HPW = (HEADER_CHARS > 1) ? $clog2(HEADER_CHARS) : 1;
	localparam int FIW = $clog2(ANGLE_FIELDS + 2);

	// Header register and its characters
	logic [HW-1:0]                 header_q;
	logic [aasp_pkg::BYTE_W-1:0]   hdr_chr [HEADER_CHARS];

	// Input stage
	logic                          valid_s1;
	logic [aasp_pkg::BYTE_W-1:0]   byte_s1;

	// Sentence tracker state
	logic                          in_sent_q,  in_sent_d;
	logic [PW-1:0]                 pos_q,      pos_d;
	logic                          matched_q,  matched_d;
	logic [FIW-1:0]                fidx_q,     fidx_d;
	aasp_pkg::aasp_angle_t         pending_q   [ANGLE_FIELDS];
	aasp_pkg::aasp_angle_t         pending_d   [ANGLE_FIELDS];
	aasp_pkg::aasp_angle_t         stored_q    [ANGLE_FIELDS];
	aasp_pkg::aasp_angle_t         stored_d    [ANGLE_FIELDS];
	aasp_pkg::aasp_angle_t         pend_commit [ANGLE_FIELDS];
	aasp_pkg::aasp_angle_t         angle_next  [3];

	// Result register
	logic                          res_valid_q;
	logic                          ok_q;
	aasp_pkg::aasp_angle_t         yaw_q, pitch_q, roll_q;

	// Per-byte decode
	logic                          is_hdr0;
	logic                          emit;
	logic                          ok;
	logic                          in_field;
	logic                          res_free;
	logic                          fire;
	aasp_pkg::aasp_field_ctl_t     fctl;
	aasp_pkg::aasp_field_ctl_t     fctl_gated;
	aasp_pkg::aasp_angle_t         field_value;

	for (genvar i = 0; i < HEADER_CHARS; i++) begin : g_hdr
		assign hdr_chr[i] = header_q[HW-1-8*i -: 8];
	end

	// Header register, written from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET[HW-1:0];
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	// Advance the byte stage when it is empty or its byte is processed
	assign res_free = !res_valid_q || res_ready;
	assign fire     = valid_s1 && (!emit || res_free);
	assign rx_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	aasp_field_acc u_field (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl_gated),
		.char_in (byte_s1),
		.value   (field_value)
	);

	// Pending angles with the current field committed
	always_comb begin
		for (int i = 0; i < ANGLE_FIELDS; i++) begin
			pend_commit[i] = (fidx_q == FIW'(i + 1)) ? field_value : pending_q[i];
		end
	end

	// Sentence tracker: next state for the byte in the input stage
	always_comb begin
		is_hdr0   = (byte_s1 == hdr_chr[0]);
		emit      = !is_hdr0 && (byte_s1 == aasp_pkg::CHAR_STAR);
		ok        = in_sent_q && matched_q && (pos_q == PW'(HEADER_CHARS));
		in_field  = (fidx_q != '0) && (fidx_q <= FIW'(ANGLE_FIELDS));
		in_sent_d = in_sent_q;
		pos_d     = pos_q;
		matched_d = matched_q;
		fidx_d    = fidx_q;
		fctl      = '0;
		for (int i = 0; i < ANGLE_FIELDS; i++) begin
			pending_d[i] = pending_q[i];
			stored_d[i]  = stored_q[i];
		end

		if (is_hdr0) begin
			// restart: drop the pending angles and field state the last sentence left
			in_sent_d = 1'b1;
			pos_d     = PW'(1);
			matched_d = 1'b1;
			fidx_d    = '0;
			fctl.clear = 1'b1;
			for (int i = 0; i < ANGLE_FIELDS; i++) begin
				pending_d[i] = '0;
			end
		end else if (emit) begin
			if (ok) begin
				for (int i = 0; i < ANGLE_FIELDS; i++) begin
					stored_d[i] = pend_commit[i];
				end
			end
			in_sent_d = 1'b0;
		end else if (!in_sent_q) begin
			// outside a sentence: ignore
		end else if (pos_q < PW'(HEADER_CHARS)) begin
			if (byte_s1 != hdr_chr[pos_q[HPW-1:0]]) begin
				matched_d = 1'b0;
			end
			pos_d = pos_q + PW'(1);
		end else if (byte_s1 == aasp_pkg::CHAR_COMMA) begin
			for (int i = 0; i < ANGLE_FIELDS; i++) begin
				pending_d[i] = pend_commit[i];
			end
			if (fidx_q <= FIW'(ANGLE_FIELDS)) begin
				fidx_d = fidx_q + FIW'(1);
			end
			fctl.clear = 1'b1;
		end else if (in_field) begin
			fctl.take = 1'b1;
		end

		fctl_gated = fire ? fctl : '0;
	end

	// Angles offered with a result: the first three stored angles, zero past the last
	for (genvar j = 0; j < 3; j++) begin : g_out
		if (j < ANGLE_FIELDS) begin : g_used
			assign angle_next[j] = stored_d[j];
		end else begin : g_unused
			assign angle_next[j] = '0;
		end
	end

	// Commit tracker state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			pos_q     <= '0;
			matched_q <= 1'b0;
			fidx_q    <= '0;
			for (int i = 0; i < ANGLE_FIELDS; i++) begin
				pending_q[i] <= '0;
				stored_q[i]  <= '0;
			end
		end else if (fire) begin
			in_sent_q <= in_sent_d;
			pos_q     <= pos_d;
			matched_q <= matched_d;
			fidx_q    <= fidx_d;
			for (int i = 0; i < ANGLE_FIELDS; i++) begin
				pending_q[i] <= pending_d[i];
				stored_q[i]  <= stored_d[i];
			end
		end
	end

	// Result register: load on '*', drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			ok_q    <= ok;
			yaw_q   <= angle_next[0];
			pitch_q <= angle_next[1];
			roll_q  <= angle_next[2];
		end
	end

	assign res_valid   = res_valid_q;
	assign sentence_ok = ok_q;
	assign yaw_milli   = yaw_q;
	assign pitch_milli = pitch_q;
	assign roll_milli  = roll_q;

endmodule

`default_nettype wire
